### rtl/core/triangle_tangent_bitangent_core_assert.svh
// Assertion macros used by the checker of this block.
`ifndef TRIANGLE_TANGENT_BITANGENT_CORE_ASSERT_SVH
`define TRIANGLE_TANGENT_BITANGENT_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TTB_ASSERT_NOW(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define TTB_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

### rtl/core/ttb_pkg.sv
package ttb_pkg;

  localparam int COMPONENT_BITS_DEF = 16;

  // normalizer: largest magnitude lands with its top bit at NORM_TOP
  localparam int NORM_TOP   = 29;
  localparam int SQ_W       = NORM_TOP + 1;
  localparam int SUM_W      = 2 * SQ_W + 2;
  localparam int ROOT_W     = SUM_W / 2;
  localparam int SQRT_STEPS = ROOT_W;
  // or-word, msb, shift, square, sum
  localparam int NORM_FRONT = 5;

  // front stages + root steps + prep + (c-1) divide steps + sign
  function automatic int norm_stages(input int c);
    return NORM_FRONT + SQRT_STEPS + c + 1;
  endfunction

endpackage

### rtl/core/ttb_if.sv
interface ttb_in_if import ttb_pkg::*; #(
  parameter int COMPONENT_BITS = COMPONENT_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic [3*COMPONENT_BITS-1:0] position_a;
  logic [3*COMPONENT_BITS-1:0] position_b;
  logic [3*COMPONENT_BITS-1:0] position_c;
  logic [2*COMPONENT_BITS-1:0] texcoord_a;
  logic [2*COMPONENT_BITS-1:0] texcoord_b;
  logic [2*COMPONENT_BITS-1:0] texcoord_c;

  modport source (output valid, position_a, position_b, position_c,
                  texcoord_a, texcoord_b, texcoord_c, input ready);
  modport sink   (input valid, position_a, position_b, position_c,
                  texcoord_a, texcoord_b, texcoord_c, output ready);
endinterface

interface ttb_out_if import ttb_pkg::*; #(
  parameter int COMPONENT_BITS = COMPONENT_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic [3*COMPONENT_BITS-1:0] tangent_dir;
  logic [3*COMPONENT_BITS-1:0] bitangent_dir;
  logic                        degenerate;

  modport source (output valid, tangent_dir, bitangent_dir, degenerate, input ready);
  modport sink   (input valid, tangent_dir, bitangent_dir, degenerate, output ready);
endinterface

### rtl/core/ttb_norm.sv
module ttb_norm import ttb_pkg::*; #(
  parameter int COMPONENT_BITS = COMPONENT_BITS_DEF,
  parameter int MAG_BITS       = 2 * COMPONENT_BITS + 3
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [2:0][MAG_BITS-1:0]    mag_i,
  input  logic [2:0]                  neg_i,
  output logic [3*COMPONENT_BITS-1:0] dir_o,
  output logic                        zero_o
);

  localparam int C   = COMPONENT_BITS;
  localparam int QB  = C - 1;
  localparam int PBW = ($clog2(MAG_BITS) > 5) ? $clog2(MAG_BITS) : 5;
  localparam int XW  = MAG_BITS + NORM_TOP;
  localparam int NW  = SQ_W + C - 1;
  localparam int RW  = ROOT_W + 1;

  typedef struct packed {
    logic [2:0][SQ_W-1:0] sh;
    logic [2:0]           neg;
    logic                 zero;
  } carry_t;

  // or-word: its top bit is the top bit of the largest magnitude
  logic [2:0][MAG_BITS-1:0] a_mag_r;
  logic [2:0]               a_neg_r;
  logic [MAG_BITS-1:0]      a_or_r;

  always_ff @(posedge clk) begin
    if (en) begin
      a_mag_r <= mag_i;
      a_neg_r <= neg_i;
      a_or_r  <= mag_i[0] | mag_i[1] | mag_i[2];
    end
  end

  // leading-one position
  logic [PBW-1:0]           msb_nxt;
  logic [PBW-1:0]           b_msb_r;
  logic [2:0][MAG_BITS-1:0] b_mag_r;
  logic [2:0]               b_neg_r;
  logic                     b_zero_r;

  always_comb begin
    msb_nxt = '0;
    for (int k = 0; k < MAG_BITS; k++) begin
      if (a_or_r[k]) msb_nxt = PBW'(k);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_msb_r  <= msb_nxt;
      b_mag_r  <= a_mag_r;
      b_neg_r  <= a_neg_r;
      b_zero_r <= (a_or_r == '0);
    end
  end

  // align to NORM_TOP; right shifts truncate
  logic [2:0][SQ_W-1:0] sh_nxt;
  carry_t               c_r;

  always_comb begin
    logic [XW-1:0] wide;
    for (int i = 0; i < 3; i++) begin
      wide = XW'(b_mag_r[i]);
      if (b_msb_r < PBW'(NORM_TOP)) begin
        wide = wide << (PBW'(NORM_TOP) - b_msb_r);
      end else begin
        wide = wide >> (b_msb_r - PBW'(NORM_TOP));
      end
      sh_nxt[i] = wide[SQ_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_r.sh   <= sh_nxt;
      c_r.neg  <= b_neg_r;
      c_r.zero <= b_zero_r;
    end
  end

  // squares
  logic [2:0][2*SQ_W-1:0] d_sq_r;
  carry_t                 d_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) d_sq_r[i] <= c_r.sh[i] * c_r.sh[i];
      d_r <= c_r;
    end
  end

  // root pipeline; entry 0 holds the sum of squares
  logic [SUM_W-1:0] rt_s_r [SQRT_STEPS+1];
  logic [SUM_W-1:0] rt_q_r [SQRT_STEPS+1];
  carry_t           rt_c_r [SQRT_STEPS+1];
  logic [SUM_W-1:0] rt_t   [1:SQRT_STEPS];

  always_comb begin
    for (int g = 1; g <= SQRT_STEPS; g++) begin
      rt_t[g] = rt_q_r[g-1] + (SUM_W'(1) << (2 * (SQRT_STEPS - g)));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rt_s_r[0] <= SUM_W'(d_sq_r[0]) + SUM_W'(d_sq_r[1]) + SUM_W'(d_sq_r[2]);
      rt_q_r[0] <= '0;
      rt_c_r[0] <= d_r;
      for (int g = 1; g <= SQRT_STEPS; g++) begin
        if (rt_s_r[g-1] >= rt_t[g]) begin
          rt_s_r[g] <= rt_s_r[g-1] - rt_t[g];
          rt_q_r[g] <= (rt_q_r[g-1] >> 1) + (SUM_W'(1) << (2 * (SQRT_STEPS - g)));
        end else begin
          rt_s_r[g] <= rt_s_r[g-1];
          rt_q_r[g] <= rt_q_r[g-1] >> 1;
        end
        rt_c_r[g] <= rt_c_r[g-1];
      end
    end
  end

  // rounded restoring divide, one quotient bit per stage
  logic [ROOT_W-1:0]       root;
  logic [ROOT_W-1:0]       root_fix;
  logic [2:0][NW-1:0]      num;

  logic [2:0][RW-1:0]      dv_rem_r  [QB+1];
  logic [2:0][QB-1:0]      dv_low_r  [QB+1];
  logic [2:0][QB-1:0]      dv_q_r    [QB+1];
  logic [ROOT_W-1:0]       dv_root_r [QB+1];
  logic [2:0]              dv_neg_r  [QB+1];
  logic                    dv_zero_r [QB+1];
  logic [2:0][RW-1:0]      dv_trial  [1:QB];

  assign root     = rt_q_r[SQRT_STEPS][ROOT_W-1:0];
  assign root_fix = (root == '0) ? ROOT_W'(1) : root;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i] = NW'({rt_c_r[SQRT_STEPS].sh[i], {(C-2){1'b0}}}) + NW'(root_fix >> 1);
    end
    for (int d = 1; d <= QB; d++) begin
      for (int i = 0; i < 3; i++) begin
        dv_trial[d][i] = {dv_rem_r[d-1][i][RW-2:0], dv_low_r[d-1][i][QB-1]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dv_rem_r[0][i] <= RW'(num[i] >> QB);
        dv_low_r[0][i] <= num[i][QB-1:0];
        dv_q_r[0][i]   <= '0;
      end
      dv_root_r[0] <= root_fix;
      dv_neg_r[0]  <= rt_c_r[SQRT_STEPS].neg;
      dv_zero_r[0] <= rt_c_r[SQRT_STEPS].zero;
      for (int d = 1; d <= QB; d++) begin
        for (int i = 0; i < 3; i++) begin
          if (dv_trial[d][i] >= {1'b0, dv_root_r[d-1]}) begin
            dv_rem_r[d][i] <= dv_trial[d][i] - {1'b0, dv_root_r[d-1]};
            dv_q_r[d][i]   <= {dv_q_r[d-1][i][QB-2:0], 1'b1};
          end else begin
            dv_rem_r[d][i] <= dv_trial[d][i];
            dv_q_r[d][i]   <= {dv_q_r[d-1][i][QB-2:0], 1'b0};
          end
          dv_low_r[d][i] <= dv_low_r[d-1][i] << 1;
        end
        dv_root_r[d] <= dv_root_r[d-1];
        dv_neg_r[d]  <= dv_neg_r[d-1];
        dv_zero_r[d] <= dv_zero_r[d-1];
      end
    end
  end

  // quotient never exceeds 2^(C-2), so it fits the output without clamping
  logic [3*C-1:0] dir_r;
  logic           zero_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dir_r[i*C +: C] <= dv_neg_r[QB][i] ? (C'(0) - {1'b0, dv_q_r[QB][i]})
                                           : {1'b0, dv_q_r[QB][i]};
      end
      zero_r <= dv_zero_r[QB];
    end
  end

  assign dir_o  = dir_r;
  assign zero_o = zero_r;

endmodule

### rtl/core/triangle_tangent_bitangent_core.sv
// Channel   Dir  Payload                                        Handshake
// in_item   in   position_a/b/c (3xC), texcoord_a/b/c (2xC)     valid/ready
// out_item  out  tangent_dir, bitangent_dir (3xC), degenerate    valid/ready
//
// One item per cycle sustained while the skid entry is empty. Each of the two
// normalizers holds 31 one-bit root stages and C-1 one-bit divider stages.
// rst_n clears only valid bits; payload registers are not reset.
// On a stall a two-entry output (register + skid) catches the item in flight;
// the whole pipeline then holds and in_item.ready drops until the skid drains.
module triangle_tangent_bitangent_core import ttb_pkg::*; #(
  parameter int COMPONENT_BITS = COMPONENT_BITS_DEF
) (
  input logic      clk,
  input logic      rst_n,
  ttb_in_if.sink   in_item,
  ttb_out_if.source out_item
);

  localparam int C  = COMPONENT_BITS;
  localparam int DW = C + 1;          // deltas
  localparam int PW = 2 * C + 2;      // products
  localparam int VW = 2 * C + 3;      // T, B, det
  localparam int NS = norm_stages(C);
  localparam int NT = 4 + NS;

  typedef struct packed {
    logic [3*C-1:0] tangent;
    logic [3*C-1:0] bitangent;
    logic           degenerate;
  } res_t;

  // pipeline advance: held only while the skid entry is occupied
  logic          en;
  logic [NT-1:0] v_r;
  logic          sk_valid_r;

  assign en            = !sk_valid_r;
  assign in_item.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NT-2:0], in_item.valid};
    end
  end

  // unpack components
  logic signed [C-1:0] pa [3];
  logic signed [C-1:0] pb [3];
  logic signed [C-1:0] pc [3];
  logic signed [C-1:0] ua, va, ub, vb, uc, vc;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pa[i] = in_item.position_a[i*C +: C];
      pb[i] = in_item.position_b[i*C +: C];
      pc[i] = in_item.position_c[i*C +: C];
    end
    ua = in_item.texcoord_a[0 +: C];
    va = in_item.texcoord_a[C +: C];
    ub = in_item.texcoord_b[0 +: C];
    vb = in_item.texcoord_b[C +: C];
    uc = in_item.texcoord_c[0 +: C];
    vc = in_item.texcoord_c[C +: C];
  end

  // stage 0: edge and uv deltas
  logic signed [DW-1:0] s0_dp1_r [3];
  logic signed [DW-1:0] s0_dp2_r [3];
  logic signed [DW-1:0] s0_du1_r, s0_dv1_r, s0_du2_r, s0_dv2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s0_dp1_r[i] <= DW'(pb[i]) - DW'(pa[i]);
        s0_dp2_r[i] <= DW'(pc[i]) - DW'(pa[i]);
      end
      s0_du1_r <= DW'(ub) - DW'(ua);
      s0_dv1_r <= DW'(vb) - DW'(va);
      s0_du2_r <= DW'(uc) - DW'(ua);
      s0_dv2_r <= DW'(vc) - DW'(va);
    end
  end

  // stage 1: cross products
  logic signed [PW-1:0] s1_pt1_r [3];
  logic signed [PW-1:0] s1_pt2_r [3];
  logic signed [PW-1:0] s1_pb1_r [3];
  logic signed [PW-1:0] s1_pb2_r [3];
  logic signed [PW-1:0] s1_pd1_r, s1_pd2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_pt1_r[i] <= s0_dp1_r[i] * s0_dv2_r;
        s1_pt2_r[i] <= s0_dp2_r[i] * s0_dv1_r;
        s1_pb1_r[i] <= s0_dp2_r[i] * s0_du1_r;
        s1_pb2_r[i] <= s0_dp1_r[i] * s0_du2_r;
      end
      s1_pd1_r <= s0_du1_r * s0_dv2_r;
      s1_pd2_r <= s0_dv1_r * s0_du2_r;
    end
  end

  // stage 2: T, B and det, exact
  logic signed [VW-1:0] s2_t_r [3];
  logic signed [VW-1:0] s2_b_r [3];
  logic signed [VW-1:0] s2_det_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s2_t_r[i] <= VW'(s1_pt1_r[i]) - VW'(s1_pt2_r[i]);
        s2_b_r[i] <= VW'(s1_pb1_r[i]) - VW'(s1_pb2_r[i]);
      end
      s2_det_r <= VW'(s1_pd1_r) - VW'(s1_pd2_r);
    end
  end

  // stage 3: sign-magnitude; a negative det flips every sign
  logic [2:0][VW-1:0] s3_tmag_r, s3_bmag_r;
  logic [2:0]         s3_tneg_r, s3_bneg_r;
  logic               dz_r [NS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s3_tmag_r[i] <= s2_t_r[i][VW-1] ? VW'(-s2_t_r[i]) : VW'(s2_t_r[i]);
        s3_bmag_r[i] <= s2_b_r[i][VW-1] ? VW'(-s2_b_r[i]) : VW'(s2_b_r[i]);
        s3_tneg_r[i] <= s2_t_r[i][VW-1] ^ s2_det_r[VW-1];
        s3_bneg_r[i] <= s2_b_r[i][VW-1] ^ s2_det_r[VW-1];
      end
      dz_r[0] <= (s2_det_r == '0);
      for (int k = 1; k <= NS; k++) dz_r[k] <= dz_r[k-1];
    end
  end

  // stages 4 .. NT-1: two normalizers in lockstep
  logic [3*C-1:0] t_dir, b_dir;
  logic           t_zero, b_zero;

  ttb_norm #(.COMPONENT_BITS(C), .MAG_BITS(VW)) u_norm_t (
    .clk    (clk),
    .en     (en),
    .mag_i  (s3_tmag_r),
    .neg_i  (s3_tneg_r),
    .dir_o  (t_dir),
    .zero_o (t_zero)
  );

  ttb_norm #(.COMPONENT_BITS(C), .MAG_BITS(VW)) u_norm_b (
    .clk    (clk),
    .en     (en),
    .mag_i  (s3_bmag_r),
    .neg_i  (s3_bneg_r),
    .dir_o  (b_dir),
    .zero_o (b_zero)
  );

  res_t res;

  always_comb begin
    res.degenerate = dz_r[NS] || t_zero || b_zero;
    res.tangent    = res.degenerate ? '0 : t_dir;
    res.bitangent  = res.degenerate ? '0 : b_dir;
  end

  // output register + skid
  logic out_valid_r;
  res_t out_r, sk_r;
  logic push, pop;

  assign push = en && v_r[NT-1];
  assign pop  = out_valid_r && out_item.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sk_valid_r  <= 1'b0;
    end else if (sk_valid_r) begin
      if (pop) begin
        sk_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_valid_r <= 1'b1;
      end else begin
        sk_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sk_valid_r) begin
      if (pop) out_r <= sk_r;
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_r <= res;
      end else begin
        sk_r <= res;
      end
    end
  end

  assign out_item.valid         = out_valid_r;
  assign out_item.tangent_dir   = out_r.tangent;
  assign out_item.bitangent_dir = out_r.bitangent;
  assign out_item.degenerate    = out_r.degenerate;

endmodule

### rtl/core/ttb_check.sv
`include "triangle_tangent_bitangent_core_assert.svh"

module ttb_check import ttb_pkg::*; #(
  parameter int COMPONENT_BITS = COMPONENT_BITS_DEF
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [3*COMPONENT_BITS-1:0] tangent_dir,
  input logic [3*COMPONENT_BITS-1:0] bitangent_dir,
  input logic                        degenerate
);

  `TTB_ASSERT_NOW(a_degen_zero, out_valid && degenerate,
    tangent_dir == '0 && bitangent_dir == '0, "degenerate item with nonzero vectors")

  `TTB_ASSERT_NOW(a_unit_nonzero, out_valid && !degenerate,
    tangent_dir != '0 && bitangent_dir != '0, "good item with a zero vector")

  `TTB_ASSERT_NOW(a_hold_only_full, !in_ready, out_valid, "input held with no item out")

  `TTB_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready,
    out_valid && $stable(tangent_dir) && $stable(bitangent_dir) && $stable(degenerate),
    "stalled item changed")

endmodule

bind triangle_tangent_bitangent_core ttb_check #(.COMPONENT_BITS(COMPONENT_BITS)) u_check (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_item.ready),
  .out_valid     (out_item.valid),
  .out_ready     (out_item.ready),
  .tangent_dir   (out_item.tangent_dir),
  .bitangent_dir (out_item.bitangent_dir),
  .degenerate    (out_item.degenerate)
);

### tb/tb_triangle_tangent_bitangent_core.sv
`timescale 1ns / 100ps

module tb_triangle_tangent_bitangent_core;
  import ttb_pkg::*;

  localparam int CB        = COMPONENT_BITS_DEF;
  localparam int FRAC      = CB - 2;
  localparam int LATENCY   = 41 + CB;
  localparam int N_RANDOM  = 1200;
  localparam int CYC_LIMIT = 400000;

  typedef struct {
    logic [3*CB-1:0] pos_a, pos_b, pos_c;
    logic [2*CB-1:0] uv_a, uv_b, uv_c;
  } tri_t;

  typedef struct {
    logic [3*CB-1:0] tangent;
    logic [3*CB-1:0] bitangent;
    logic            degen;
  } frame_t;

  typedef struct {
    tri_t   shape;
    bit     typed;   // expectation typed in below, not predicted
    frame_t frame;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ttb_in_if  #(.COMPONENT_BITS(CB)) in_if ();
  ttb_out_if #(.COMPONENT_BITS(CB)) out_if ();

  triangle_tangent_bitangent_core #(.COMPONENT_BITS(CB)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_item (in_if),
    .out_item(out_if)
  );

  always #5 clk = ~clk;

  frame_t frames_due[$];      // expected frames, oldest first
  bit     typed_due[$];       // per sent item: typed expectation present
  frame_t typed_frame[$];
  int     n_accepted = 0;
  int     n_results  = 0;
  int     n_degen    = 0;
  int     n_errors   = 0;
  int     cycles     = 0;

  // ---------------------------------------------------------------------
  // Predictor: exact integer tangent frame, then fixed-point normalize
  // ---------------------------------------------------------------------
  function automatic longint comp_of(logic [3*CB-1:0] w, int idx);
    logic signed [CB-1:0] c;
    c = w[idx*CB +: CB];
    return longint'(c);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned s);
    longint unsigned res, one;
    res = 0;
    one = 64'd1 << 62;
    while (one > s) one >>= 2;
    while (one != 0) begin
      if (s >= res + one) begin
        s -= res + one;
        res = (res >> 1) + one;
      end else begin
        res >>= 1;
      end
      one >>= 2;
    end
    return res;
  endfunction

  // returns 0 for a zero-length vector
  function automatic bit unit_dir(longint v[3], output logic [3*CB-1:0] packed_dir);
    longint unsigned mag[3], big, sum, r, q, lim;
    bit neg[3];
    int msb;
    big = 0;
    msb = 0;
    sum = 0;
    packed_dir = '0;
    lim = (64'd1 << (CB - 1)) - 1;
    for (int i = 0; i < 3; i++) begin
      neg[i] = v[i] < 0;
      mag[i] = neg[i] ? longint'(-v[i]) : longint'(v[i]);
      if (mag[i] > big) big = mag[i];
    end
    if (big == 0) return 0;
    while (msb < 63 && (big >> (msb + 1)) != 0) msb++;
    for (int i = 0; i < 3; i++) begin
      if (msb < NORM_TOP) mag[i] = mag[i] << (NORM_TOP - msb);
      else mag[i] = mag[i] >> (msb - NORM_TOP);
      sum += mag[i] * mag[i];
    end
    r = int_sqrt(sum);
    if (r == 0) r = 1;
    for (int i = 0; i < 3; i++) begin
      q = ((mag[i] << FRAC) + (r >> 1)) / r;
      if (q > lim) q = lim;
      if (neg[i]) q = -q;
      packed_dir[i*CB +: CB] = q[CB-1:0];
    end
    return 1;
  endfunction

  function automatic frame_t tangent_frame(tri_t t);
    frame_t f;
    longint e1[3], e2[3], tv[3], bv[3];
    longint du1, dv1, du2, dv2, det;
    bit ok;
    for (int i = 0; i < 3; i++) begin
      e1[i] = comp_of(t.pos_b, i) - comp_of(t.pos_a, i);
      e2[i] = comp_of(t.pos_c, i) - comp_of(t.pos_a, i);
    end
    du1 = comp_of(t.uv_b, 0) - comp_of(t.uv_a, 0);
    dv1 = comp_of(t.uv_b, 1) - comp_of(t.uv_a, 1);
    du2 = comp_of(t.uv_c, 0) - comp_of(t.uv_a, 0);
    dv2 = comp_of(t.uv_c, 1) - comp_of(t.uv_a, 1);
    det = du1 * dv2 - dv1 * du2;
    f.tangent = '0;
    f.bitangent = '0;
    ok = det != 0;
    if (ok) begin
      for (int i = 0; i < 3; i++) begin
        tv[i] = e1[i] * dv2 - e2[i] * dv1;
        bv[i] = e2[i] * du1 - e1[i] * du2;
        if (det < 0) begin
          tv[i] = -tv[i];
          bv[i] = -bv[i];
        end
      end
      ok = unit_dir(tv, f.tangent);
      if (ok) ok = unit_dir(bv, f.bitangent);
    end
    if (!ok) begin
      f.tangent = '0;
      f.bitangent = '0;
    end
    f.degen = !ok;
    return f;
  endfunction

  task automatic report(string what, logic [3*CB-1:0] got, logic [3*CB-1:0] want);
    n_errors++;
    $display("MISMATCH @%0t result %0d %s: got %h want %h", $realtime, n_results,
             what, got, want);
  endtask

  // ---------------------------------------------------------------------
  // Monitor: inputs change at negedge, both channels sampled at posedge
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    tri_t   t;
    frame_t f, want;
    cycles++;
    if (cycles > CYC_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results pending", cycles, frames_due.size());
      $display("Test completed with failures");
      $finish;
    end
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        t.pos_a = in_if.position_a;
        t.pos_b = in_if.position_b;
        t.pos_c = in_if.position_c;
        t.uv_a  = in_if.texcoord_a;
        t.uv_b  = in_if.texcoord_b;
        t.uv_c  = in_if.texcoord_c;
        f = tangent_frame(t);
        if (typed_due.pop_front()) f = typed_frame.pop_front();
        frames_due.push_back(f);
        n_accepted++;
      end
      if (out_if.valid && out_if.ready) begin
        if (frames_due.size() == 0) begin
          report("unexpected tangent_dir", out_if.tangent_dir, '0);
        end else begin
          want = frames_due.pop_front();
          if (out_if.tangent_dir !== want.tangent)
            report("tangent_dir", out_if.tangent_dir, want.tangent);
          if (out_if.bitangent_dir !== want.bitangent)
            report("bitangent_dir", out_if.bitangent_dir, want.bitangent);
          if (out_if.degenerate !== want.degen)
            report("degenerate", (3*CB)'(out_if.degenerate), (3*CB)'(want.degen));
          if (out_if.degenerate === 1'b1) n_degen++;
        end
        n_results++;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: stall pattern rotates through four modes, chosen from elapsed cycles
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    case ((cycles / 300) % 4)
      0: begin
        out_if.ready <= 1'b1;
      end
      1: begin
        out_if.ready <= ($urandom_range(0, 9) < 7);
      end
      2: begin
        out_if.ready <= (cycles % 16) < 5;
      end
      default: begin
        out_if.ready <= ($urandom_range(0, 3) != 0);
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------
  int burst_left = 0;

  task automatic send(tri_t t, bit typed, frame_t f);
    int taken;
    if (burst_left == 0) begin
      in_if.valid = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    typed_due.push_back(typed);
    if (typed) typed_frame.push_back(f);
    in_if.position_a = t.pos_a;
    in_if.position_b = t.pos_b;
    in_if.position_c = t.pos_c;
    in_if.texcoord_a = t.uv_a;
    in_if.texcoord_b = t.uv_b;
    in_if.texcoord_c = t.uv_c;
    in_if.valid = 1'b1;
    taken = n_accepted;
    do @(negedge clk); while (n_accepted == taken);
  endtask

  function automatic logic [3*CB-1:0] pos3(int x, int y, int z);
    return {CB'(z), CB'(y), CB'(x)};
  endfunction

  function automatic logic [2*CB-1:0] uv2(int u, int v);
    return {CB'(v), CB'(u)};
  endfunction

  // random triangle; mostly well-formed, some degenerate by construction
  function automatic tri_t random_tri();
    tri_t t;
    int kind;
    t.pos_a = (3*CB)'({$urandom(), $urandom()});
    t.pos_b = (3*CB)'({$urandom(), $urandom()});
    t.pos_c = (3*CB)'({$urandom(), $urandom()});
    t.uv_a  = (2*CB)'($urandom());
    t.uv_b  = (2*CB)'($urandom());
    t.uv_c  = (2*CB)'($urandom());
    kind = $urandom_range(0, 11);
    case (kind)
      6: begin
        t.pos_b = t.pos_a;
      end
      7: begin
        t.uv_c = t.uv_b;              // zero UV determinant
      end
      8: begin
        t.pos_b = t.pos_a;            // no area at all
        t.pos_c = t.pos_a;
      end
      9, 10: begin                    // small mesh-like deltas
        for (int i = 0; i < 3; i++) begin
          t.pos_b[i*CB +: CB] = t.pos_a[i*CB +: CB] + CB'($urandom_range(0, 64) - 32);
          t.pos_c[i*CB +: CB] = t.pos_a[i*CB +: CB] + CB'($urandom_range(0, 64) - 32);
        end
        for (int i = 0; i < 2; i++) begin
          t.uv_b[i*CB +: CB] = t.uv_a[i*CB +: CB] + CB'($urandom_range(0, 512) - 256);
          t.uv_c[i*CB +: CB] = t.uv_a[i*CB +: CB] + CB'($urandom_range(0, 512) - 256);
        end
      end
      default: begin
      end
    endcase
    return t;
  endfunction

  row_t   rows[$];
  frame_t none;
  int     n_rows;

  task automatic add_row(tri_t t, bit typed, frame_t f);
    row_t r;
    r.shape = t;
    r.typed = typed;
    r.frame = f;
    rows.push_back(r);
  endtask

  initial begin
    tri_t   t;
    frame_t f;
    none = '{default: '0};

    in_if.valid = 1'b0;
    in_if.position_a = '0;
    in_if.position_b = '0;
    in_if.position_c = '0;
    in_if.texcoord_a = '0;
    in_if.texcoord_b = '0;
    in_if.texcoord_c = '0;
    out_if.ready = 1'b0;

    // all zero: zero determinant, degenerate
    t = '{default: '0};
    f = '{tangent: '0, bitangent: '0, degen: 1'b1};
    add_row(t, 1, f);
    // right triangle with aligned UVs: T along x, B along y
    t.pos_a = pos3(0, 0, 0);
    t.pos_b = pos3(256, 0, 0);
    t.pos_c = pos3(0, 256, 0);
    t.uv_a = uv2(0, 0);
    t.uv_b = uv2(16384, 0);
    t.uv_c = uv2(0, 16384);
    f = '{tangent: pos3(16384, 0, 0), bitangent: pos3(0, 16384, 0), degen: 1'b0};
    add_row(t, 1, f);
    // same with V flipped: negative determinant
    t.uv_c = uv2(0, -16384);
    add_row(t, 0, none);
    // good UVs but all positions equal: zero-length T and B
    t.pos_b = t.pos_a;
    t.pos_c = t.pos_a;
    t.uv_c = uv2(0, 16384);
    f = '{tangent: '0, bitangent: '0, degen: 1'b1};
    add_row(t, 1, f);
    // collinear UVs: zero determinant with a real triangle
    t.pos_b = pos3(100, -7, 3);
    t.pos_c = pos3(-20, 55, 9);
    t.uv_b = uv2(1000, 2000);
    t.uv_c = uv2(2000, 4000);
    f = '{tangent: '0, bitangent: '0, degen: 1'b1};
    add_row(t, 1, f);
    // field extremes, most negative against most positive
    t.pos_a = pos3(-32768, -32768, -32768);
    t.pos_b = pos3(32767, -32768, 32767);
    t.pos_c = pos3(-32768, 32767, 32767);
    t.uv_a = uv2(-32768, -32768);
    t.uv_b = uv2(32767, -32768);
    t.uv_c = uv2(-32768, 32767);
    add_row(t, 0, none);
    t.pos_a = pos3(32767, 32767, 32767);
    t.pos_b = pos3(-32768, -32768, -32768);
    t.pos_c = pos3(32767, -32768, 0);
    t.uv_a = uv2(32767, 32767);
    t.uv_b = uv2(-32768, 32767);
    t.uv_c = uv2(32767, -32768);
    add_row(t, 0, none);
    // tiny deltas: smallest nonzero edge and UV steps
    t.pos_a = pos3(5, 5, 5);
    t.pos_b = pos3(6, 5, 5);
    t.pos_c = pos3(5, 5, 6);
    t.uv_a = uv2(-1, -1);
    t.uv_b = uv2(0, -1);
    t.uv_c = uv2(-1, 0);
    add_row(t, 0, none);
    // all ones in every field of vertex a
    t.pos_a = '1; t.pos_b = pos3(1, 2, 3); t.pos_c = pos3(-3, 7, -1);
    t.uv_a = '1; t.uv_b = uv2(9, -4); t.uv_c = uv2(-6, 11);
    add_row(t, 0, none);
    // skewed triangle, one component dominant
    t.pos_a = pos3(0, 0, 0);
    t.pos_b = pos3(30000, 1, -1);
    t.pos_c = pos3(-2, 3, 30000);
    t.uv_a = uv2(0, 0); t.uv_b = uv2(1, 16000); t.uv_c = uv2(15000, -3);
    add_row(t, 0, none);
    n_rows = rows.size();

    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (rows[i]) send(rows[i].shape, rows[i].typed, rows[i].frame);

    for (int i = 0; i < N_RANDOM; i++) begin
      send(random_tri(), 0, none);
      // hold off once until the pipeline has fully drained
      if (i == N_RANDOM / 2) begin
        in_if.valid = 1'b0;
        while (frames_due.size() != 0) @(negedge clk);
      end
    end
    in_if.valid = 1'b0;

    while (frames_due.size() != 0) @(negedge clk);
    repeat (LATENCY + 20) @(negedge clk);

    $display("Ran %0d directed and %0d random triangles, %0d results checked",
             n_rows, N_RANDOM, n_results);
    $display("%0d degenerate results, bursty sender and staged stalls on the output",
             n_degen);
    if (n_errors == 0 && frames_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
